// File: hdl/ppd_pkg.sv
// Package for the polyline point decimator: widths, codes, CORDIC table, command types.
`default_nettype none
package ppd_pkg;

    localparam int COORD_BITS      = 12;
    localparam int ANGLE_FRAC_BITS = 13;

    localparam int CW       = COORD_BITS;
    localparam int DW       = CW + 1;                 // signed coordinate difference
    localparam int SQW      = 2 * CW;                 // one squared term
    localparam int D2W      = SQW + 1;                // sum of two squares
    localparam int TDATA_W  = ((2 * CW + 7) / 8) * 8;

    localparam int AW       = ANGLE_FRAC_BITS + 3;    // signed angle, +-pi fits
    localparam int THR_W    = AW;
    localparam int CFG_W    = (THR_W > CW) ? THR_W : CW;
    localparam int CFG_AW   = 2;

    localparam int CORDIC_SCALE = 20;
    localparam int CORDIC_ITERS = ANGLE_FRAC_BITS + 4;
    localparam int ITER_W       = $clog2(CORDIC_ITERS);
    localparam int TAB_W        = 5;
    localparam int CXW          = CW + CORDIC_SCALE + 3;
    localparam int ZW           = 34;
    localparam int MAGW         = ZW - 1;
    localparam int RND_S        = 30 - ANGLE_FRAC_BITS;

    localparam logic signed [ZW-1:0] PI_Q30   = ZW'(64'sd3373259426);
    localparam logic [MAGW:0]        RND_HALF = (MAGW + 1)'(1) << (RND_S - 1);

    localparam logic [CW-1:0]    NEAR_RST = CW'(10);
    localparam logic [CW-1:0]    FAR_RST  = CW'(50);
    localparam logic [THR_W-1:0] THR_RST  = THR_W'(1001);

    // configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_NEAR = 2'd0,
        CFG_FAR  = 2'd1,
        CFG_THR  = 2'd2,
        CFG_NONE = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MUL_DX   = 2'd0,
        MUL_DY   = 2'd1,
        MUL_FAR  = 2'd2,
        MUL_NEAR = 2'd3
    } t_mul_sel;

    typedef enum logic [1:0] {
        D2_HOLD = 2'd0,
        D2_LOAD = 2'd1,
        D2_ADD  = 2'd2
    } t_d2_op;

    typedef struct packed {
        logic              latch_pt;
        logic              origin_save;
        logic              pending_save;
        logic              ang_load;
        logic              ang_src_pend;
        logic              ang_step;
        logic [ITER_W-1:0] ang_iter;
        logic              ang_fin1;
        logic              ang_fin2;
        logic              ref_save;
        logic              ang_cmp;
        logic              mul_en;
        t_mul_sel          mul_sel;
        t_d2_op            d2_op;
        logic              cmp_far;
        logic              cmp_near;
        logic              emit;
        logic              emit_pend;
        logic              emit_run_last;
    } t_dp_cmd;

    typedef struct packed {
        logic pt_last;
        logic out_free;
        logic turn;
        logic far_gt;
        logic near_lt;
    } t_dp_sts;

    // atan(2^-i) in Q30
    function automatic logic signed [ZW-1:0] atan_entry(input logic [TAB_W-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:  v = ZW'(843314857);
            5'd1:  v = ZW'(497837829);
            5'd2:  v = ZW'(263043837);
            5'd3:  v = ZW'(133525159);
            5'd4:  v = ZW'(67021687);
            5'd5:  v = ZW'(33543516);
            5'd6:  v = ZW'(16775851);
            5'd7:  v = ZW'(8388437);
            5'd8:  v = ZW'(4194283);
            5'd9:  v = ZW'(2097149);
            5'd10: v = ZW'(1048576);
            5'd11: v = ZW'(524288);
            5'd12: v = ZW'(262144);
            5'd13: v = ZW'(131072);
            5'd14: v = ZW'(65536);
            5'd15: v = ZW'(32768);
            5'd16: v = ZW'(16384);
            5'd17: v = ZW'(8192);
            5'd18: v = ZW'(4096);
            5'd19: v = ZW'(2048);
            5'd20: v = ZW'(1024);
            5'd21: v = ZW'(512);
            5'd22: v = ZW'(256);
            5'd23: v = ZW'(128);
            5'd24: v = ZW'(64);
            5'd25: v = ZW'(32);
            5'd26: v = ZW'(16);
            5'd27: v = ZW'(8);
            5'd28: v = ZW'(4);
            5'd29: v = ZW'(2);
            5'd30: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: hdl/polyline_point_decimator.sv
// Top level of the polyline point decimator: stream ports, controller and datapath.
//
// Points of a stroke enter on the s_axis channel, one item per point, with
// s_axis_tlast on the final point. Kept points leave on m_axis: tuser marks
// the point that ends the stroke, tlast the final result of one input item
// (an item yields zero, one or two results). Thresholds come through the
// write port i_cfg_*; write them only while no item is in flight.
// Steps per item, from acceptance to the result register:
//   first point or segment origin: latch, dispatch, then issue or save
//   candidate without pending point: distance pass (shared squarer, 4 products)
//   candidate needing a direction: 17 CORDIC iterations
//   on one shift-add unit, rounding, then the distance pass
// One item is processed at a time; s_axis_tready rises again once the item
// is done, even while its last result still waits in the output register.
// A stalled m_axis holds the result register and the controller waits
// before issuing the next result. Synchronous reset clears the stroke phase
// and the output valid, and loads near 10, far 50, threshold 1001.
`default_nettype none
module polyline_point_decimator (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [ppd_pkg::CFG_AW-1:0]       i_cfg_addr,
    input  wire [ppd_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire [ppd_pkg::TDATA_W-1:0]      s_axis_tdata,  // point_x, point_y
    input  wire                             s_axis_tlast,  // stroke_last
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    output logic [ppd_pkg::TDATA_W-1:0]     m_axis_tdata,  // kept_x, kept_y
    output logic                            m_axis_tlast,  // run_last
    output logic                            m_axis_tuser   // stroke_end
);
    import ppd_pkg::*;

    t_dp_cmd       w_cmd;
    t_dp_sts       w_sts;
    logic [CW-1:0] w_out_x, w_out_y;

    ppd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    ppd_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_pt_x         (s_axis_tdata[CW-1:0]),
        .i_pt_y         (s_axis_tdata[2*CW-1:CW]),
        .i_pt_last      (s_axis_tlast),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_x        (w_out_x),
        .o_out_y        (w_out_y),
        .o_out_end      (m_axis_tuser),
        .o_out_run_last (m_axis_tlast)
    );

    assign m_axis_tdata = TDATA_W'({w_out_y, w_out_x});

    // a result that is not the last of its item never ends the stroke
    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !m_axis_tuser)
        else $error("stroke end on a non-final result");

    // the controller never overwrites a result that is still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_sts.out_free)
        else $error("result issued into an occupied output register");

    // an accepted item keeps the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input reopened right after an accepted item");

endmodule
`default_nettype wire

// File: hdl/ppd_ctrl.sv
// Controller for the point decimator: stroke phase, per-item sequencing, result issue.
`default_nettype none
module ppd_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output ppd_pkg::t_dp_cmd  o_cmd,
    input  ppd_pkg::t_dp_sts  i_sts
);
    import ppd_pkg::*;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_ORIGIN = 2'd1,
        PH_REF    = 2'd2,
        PH_SCAN   = 2'd3
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_ANG, S_FIN1, S_FIN2, S_POST, S_TURN,
        S_D0, S_D1, S_D2, S_D3, S_D4, S_CAND, S_EMIT_PEND, S_EMIT_PT
    } t_state;

    t_state            r_state,   n_state;
    t_phase            r_phase,   n_phase;
    logic              r_pending, n_pending;
    logic              r_for_ref, n_for_ref;
    logic [ITER_W-1:0] r_iter,    n_iter;

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERS - 1);

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_pending = r_pending;
        n_for_ref = r_for_ref;
        n_iter    = r_iter;
        o_cmd     = '0;
        o_cmd.ang_iter = r_iter;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_pt = 1'b1;
                    n_state        = S_DISP;
                end
            end
            S_DISP: begin
                case (r_phase)
                    PH_FIRST: begin
                        n_phase = i_sts.pt_last ? PH_FIRST : PH_ORIGIN;
                        n_state = S_EMIT_PT;
                    end
                    PH_ORIGIN: begin
                        if (i_sts.pt_last) begin
                            n_phase = PH_FIRST;
                            n_state = S_EMIT_PT;
                        end else begin
                            o_cmd.origin_save = 1'b1;
                            n_phase           = PH_REF;
                            n_state           = S_IDLE;
                        end
                    end
                    PH_REF: begin
                        o_cmd.ang_load = 1'b1;
                        n_for_ref      = 1'b1;
                        n_iter         = '0;
                        n_state        = S_ANG;
                    end
                    default: begin
                        if (r_pending) begin
                            o_cmd.ang_load     = 1'b1;
                            o_cmd.ang_src_pend = 1'b1;
                            n_for_ref          = 1'b0;
                            n_iter             = '0;
                            n_state            = S_ANG;
                        end else begin
                            n_state = S_D0;
                        end
                    end
                endcase
            end
            S_ANG: begin
                o_cmd.ang_step = 1'b1;
                if (r_iter == ITER_LAST) begin
                    n_state = S_FIN1;
                end else begin
                    n_iter = r_iter + ITER_W'(1);
                end
            end
            S_FIN1: begin
                o_cmd.ang_fin1 = 1'b1;
                n_state        = S_FIN2;
            end
            S_FIN2: begin
                o_cmd.ang_fin2 = 1'b1;
                n_state        = S_POST;
            end
            S_POST: begin
                if (r_for_ref) begin
                    o_cmd.ref_save = 1'b1;
                    n_state        = S_D0;
                end else begin
                    o_cmd.ang_cmp = 1'b1;
                    n_state       = S_TURN;
                end
            end
            S_TURN: begin
                n_pending = 1'b0;
                n_state   = i_sts.turn ? S_EMIT_PEND : S_D0;
            end
            S_EMIT_PEND: begin
                if (i_sts.out_free) begin
                    o_cmd.emit          = 1'b1;
                    o_cmd.emit_pend     = 1'b1;
                    o_cmd.emit_run_last = !i_sts.pt_last;
                    if (i_sts.pt_last) begin
                        n_phase = PH_FIRST;
                        n_state = S_EMIT_PT;
                    end else begin
                        o_cmd.origin_save = 1'b1;
                        n_phase           = PH_REF;
                        n_state           = S_IDLE;
                    end
                end
            end
            S_D0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DX;
                n_state       = S_D1;
            end
            S_D1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DY;
                o_cmd.d2_op   = D2_LOAD;
                n_state       = S_D2;
            end
            S_D2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_FAR;
                o_cmd.d2_op   = D2_ADD;
                n_state       = S_D3;
            end
            S_D3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_NEAR;
                o_cmd.cmp_far = 1'b1;
                n_state       = S_D4;
            end
            S_D4: begin
                o_cmd.cmp_near = 1'b1;
                n_state        = S_CAND;
            end
            S_CAND: begin
                n_pending = 1'b0;
                if (i_sts.pt_last) begin
                    n_phase = PH_FIRST;
                    n_state = S_EMIT_PT;
                end else if (i_sts.far_gt) begin
                    n_phase = PH_ORIGIN;
                    n_state = S_EMIT_PT;
                end else if (i_sts.near_lt) begin
                    n_phase = PH_SCAN;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.pending_save = 1'b1;
                    n_pending          = 1'b1;
                    n_phase            = PH_SCAN;
                    n_state            = S_IDLE;
                end
            end
            S_EMIT_PT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit          = 1'b1;
                    o_cmd.emit_run_last = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_FIRST;
            r_pending <= 1'b0;
            r_for_ref <= 1'b0;
            r_iter    <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_for_ref <= n_for_ref;
            r_iter    <= n_iter;
        end
    end

endmodule
`default_nettype wire

// File: hdl/ppd_datapath.sv
// Datapath for the point decimator: config, point registers, CORDIC, distance, result register.
`default_nettype none
module ppd_datapath (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [ppd_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  wire [ppd_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  wire [ppd_pkg::CW-1:0]          i_pt_x,
    input  wire [ppd_pkg::CW-1:0]          i_pt_y,
    input  wire                            i_pt_last,
    input  ppd_pkg::t_dp_cmd               i_cmd,
    output ppd_pkg::t_dp_sts               o_sts,
    input  wire                            i_out_ready,
    output logic                           o_out_valid,
    output logic [ppd_pkg::CW-1:0]         o_out_x,
    output logic [ppd_pkg::CW-1:0]         o_out_y,
    output logic                           o_out_end,
    output logic                           o_out_run_last
);
    import ppd_pkg::*;

    logic [CW-1:0]    r_near, r_far;
    logic [THR_W-1:0] r_thr;

    logic [CW-1:0] r_pt_x, r_pt_y, r_org_x, r_org_y, r_pend_x, r_pend_y;
    logic          r_pt_last;

    logic signed [CXW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0]  r_cz;
    logic [MAGW-1:0]       r_mag;
    logic                  r_neg;
    logic signed [AW-1:0]  r_angle, r_ref;
    logic                  r_turn;

    logic [SQW-1:0] r_prod;
    logic [D2W-1:0] r_d2;
    logic           r_far_gt, r_near_lt;

    logic          r_out_valid, r_out_end, r_out_run_last;
    logic [CW-1:0] r_out_x, r_out_y;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= NEAR_RST;
            r_far  <= FAR_RST;
            r_thr  <= THR_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_NEAR: r_near <= i_cfg_wdata[CW-1:0];
                CFG_FAR:  r_far  <= i_cfg_wdata[CW-1:0];
                CFG_THR:  r_thr  <= i_cfg_wdata[THR_W-1:0];
                default:  ;
            endcase
        end
    end

    // point, origin and pending candidate
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_pt) begin
            r_pt_x    <= i_pt_x;
            r_pt_y    <= i_pt_y;
            r_pt_last <= i_pt_last;
        end
        if (i_cmd.origin_save) begin
            r_org_x <= r_pt_x;
            r_org_y <= r_pt_y;
        end
        if (i_cmd.pending_save) begin
            r_pend_x <= r_pt_x;
            r_pend_y <= r_pt_y;
        end
    end

    // CORDIC vector: source point minus current point
    logic signed [DW-1:0]  w_adx, w_ady;
    logic signed [CXW-1:0] w_lx, w_ly, w_shx, w_shy;
    logic signed [ZW-1:0]  w_atan, w_zc;
    logic [MAGW:0]         w_rnd;
    logic [AW-1:0]         w_rmag;

    always_comb begin
        if (i_cmd.ang_src_pend) begin
            w_adx = $signed({1'b0, r_pend_x}) - $signed({1'b0, r_pt_x});
            w_ady = $signed({1'b0, r_pend_y}) - $signed({1'b0, r_pt_y});
        end else begin
            w_adx = $signed({1'b0, r_org_x}) - $signed({1'b0, r_pt_x});
            w_ady = $signed({1'b0, r_org_y}) - $signed({1'b0, r_pt_y});
        end
        w_lx   = CXW'(w_adx) <<< CORDIC_SCALE;
        w_ly   = CXW'(w_ady) <<< CORDIC_SCALE;
        w_shx  = r_cx >>> i_cmd.ang_iter;
        w_shy  = r_cy >>> i_cmd.ang_iter;
        w_atan = atan_entry(TAB_W'(i_cmd.ang_iter));
        if (r_cz > PI_Q30) begin
            w_zc = PI_Q30;
        end else if (r_cz < -PI_Q30) begin
            w_zc = -PI_Q30;
        end else begin
            w_zc = r_cz;
        end
        w_rnd  = ({1'b0, r_mag} + RND_HALF) >> RND_S;
        w_rmag = w_rnd[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ang_load) begin
            if (w_adx < 0) begin
                r_cx <= -w_lx;
                r_cy <= -w_ly;
                r_cz <= (w_ady >= 0) ? PI_Q30 : -PI_Q30;
            end else begin
                r_cx <= w_lx;
                r_cy <= w_ly;
                r_cz <= '0;
            end
        end else if (i_cmd.ang_step) begin
            // rotate toward the x axis; a zero y stays put
            if (r_cy > 0) begin
                r_cx <= r_cx + w_shy;
                r_cy <= r_cy - w_shx;
                r_cz <= r_cz + w_atan;
            end else if (r_cy < 0) begin
                r_cx <= r_cx - w_shy;
                r_cy <= r_cy + w_shx;
                r_cz <= r_cz - w_atan;
            end
        end
        if (i_cmd.ang_fin1) begin
            r_neg <= w_zc[ZW-1];
            r_mag <= w_zc[ZW-1] ? MAGW'(-w_zc) : MAGW'(w_zc);
        end
        if (i_cmd.ang_fin2) begin
            r_angle <= r_neg ? -$signed(w_rmag) : $signed(w_rmag);
        end
        if (i_cmd.ref_save) begin
            r_ref <= r_angle;
        end
    end

    // unwrapped direction change against the threshold
    logic signed [AW:0] w_diff;
    logic [AW:0]        w_adiff;
    always_comb begin
        w_diff  = (AW + 1)'(r_ref) - (AW + 1)'(r_angle);
        w_adiff = w_diff[AW] ? (AW + 1)'(-w_diff) : (AW + 1)'(w_diff);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ang_cmp) begin
            r_turn <= (w_adiff > {1'b0, r_thr});
        end
    end

    // shared squarer for distance and limits
    logic signed [DW-1:0]   w_mop;
    logic signed [2*DW-1:0] w_sq;
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_DX:   w_mop = $signed({1'b0, r_pt_x}) - $signed({1'b0, r_org_x});
            MUL_DY:   w_mop = $signed({1'b0, r_pt_y}) - $signed({1'b0, r_org_y});
            MUL_FAR:  w_mop = $signed({1'b0, r_far});
            MUL_NEAR: w_mop = $signed({1'b0, r_near});
            default:  w_mop = '0;
        endcase
        w_sq = w_mop * w_mop;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= w_sq[SQW-1:0];
        end
        case (i_cmd.d2_op)
            D2_LOAD: r_d2 <= {1'b0, r_prod};
            D2_ADD:  r_d2 <= r_d2 + {1'b0, r_prod};
            default: ;
        endcase
        if (i_cmd.cmp_far) begin
            r_far_gt <= (r_d2 > {1'b0, r_prod});
        end
        if (i_cmd.cmp_near) begin
            r_near_lt <= (r_d2 < {1'b0, r_prod});
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out_x        <= i_cmd.emit_pend ? r_pend_x : r_pt_x;
            r_out_y        <= i_cmd.emit_pend ? r_pend_y : r_pt_y;
            r_out_end      <= i_cmd.emit_pend ? 1'b0 : r_pt_last;
            r_out_run_last <= i_cmd.emit_run_last;
        end
    end

    assign o_sts.pt_last  = r_pt_last;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.turn     = r_turn;
    assign o_sts.far_gt   = r_far_gt;
    assign o_sts.near_lt  = r_near_lt;

    assign o_out_valid    = r_out_valid;
    assign o_out_x        = r_out_x;
    assign o_out_y        = r_out_y;
    assign o_out_end      = r_out_end;
    assign o_out_run_last = r_out_run_last;

endmodule
`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for polyline_point_decimator: predicts kept points and checks the stream.
module testbench;

    localparam int CB            = ppd_pkg::COORD_BITS;
    localparam int AFB           = ppd_pkg::ANGLE_FRAC_BITS;
    localparam int HEADING_ITERS = AFB + 4;
    localparam int MAX_COORD     = (1 << CB) - 1;
    // +-pi in Q30, the clamp of the direction accumulator
    localparam longint HALF_TURN_Q30 = 64'sd3373259426;
    // margin for a no-result item still in flight after the last owed result
    localparam int SETTLE_CYCLES = 48;
    // cycles without any handshake or register write before the run is declared hung
    localparam int QUIET_LIMIT   = 2000;

    // one kept point as it leaves the block
    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          stroke_end;
        logic          run_last;
    } kept_point_t;

    // where the stroke tracker stands
    typedef enum logic [1:0] {
        SEEK_FIRST     = 2'd0,
        SEEK_ORIGIN    = 2'd1,
        SEEK_REFERENCE = 2'd2,
        SCAN_POINTS    = 2'd3
    } stroke_phase_t;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [ppd_pkg::CFG_AW-1:0]       i_cfg_addr;
    logic [ppd_pkg::CFG_W-1:0]        i_cfg_wdata;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [ppd_pkg::TDATA_W-1:0]      s_axis_tdata;   // point_x, point_y
    logic                             s_axis_tlast;   // stroke_last
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b1;
    logic [ppd_pkg::TDATA_W-1:0]      m_axis_tdata;   // kept_x, kept_y
    logic                             m_axis_tlast;   // run_last
    logic                             m_axis_tuser;   // stroke_end

    polyline_point_decimator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the thresholds and the stroke tracker
    // ------------------------------------------------------------------
    logic [CB-1:0]  near_cfg = ppd_pkg::NEAR_RST;
    logic [CB-1:0]  far_cfg  = ppd_pkg::FAR_RST;
    logic [15:0]    thr_cfg  = 16'(ppd_pkg::THR_RST);

    stroke_phase_t  trace_phase = SEEK_FIRST;
    logic           pend_valid  = 1'b0;
    logic [CB-1:0]  seg_org_x   = '0;
    logic [CB-1:0]  seg_org_y   = '0;
    logic [CB-1:0]  pend_x      = '0;
    logic [CB-1:0]  pend_y      = '0;
    int             ref_heading = 0;

    kept_point_t    step_run[$];        // results of the item being predicted
    kept_point_t    kept_expected[$];   // results still owed by the block
    int             mismatches = 0;

    // sender / receiver pacing
    bit             sender_gaps = 1'b0;
    int             burst_left  = 0;
    bit             rx_stalls   = 1'b1;
    int             rx_run_left = 0;
    int             quiet_cycles = 0;

    // atan(2^-i) in Q30
    function automatic longint arctan_q30(input int i);
        case (i)
            0:  return 843314857;
            1:  return 497837829;
            2:  return 263043837;
            3:  return 133525159;
            4:  return 67021687;
            5:  return 33543516;
            6:  return 16775851;
            7:  return 8388437;
            8:  return 4194283;
            9:  return 2097149;
            10: return 1048576;
            11: return 524288;
            12: return 262144;
            13: return 131072;
            14: return 65536;
            15: return 32768;
            16: return 16384;
            17: return 8192;
            18: return 4096;
            19: return 2048;
            20: return 1024;
            default: return longint'(1) << (30 - i);
        endcase
    endfunction

    // Direction of (dx, dy) in Q(AFB) radians: vectoring CORDIC on the
    // difference scaled by 2^20, flooring shifts, rounded half away from zero.
    function automatic int heading_of(input longint dy, input longint dx);
        longint vx, vy, acc, nx, mag;
        int     i;
        if (dx == 0 && dy == 0)
            return 0;
        vx  = dx * 64'sd1048576;
        vy  = dy * 64'sd1048576;
        acc = 0;
        if (vx < 0) begin
            acc = (vy >= 0) ? HALF_TURN_Q30 : -HALF_TURN_Q30;
            vx  = -vx;
            vy  = -vy;
        end
        for (i = 0; i < HEADING_ITERS && vy != 0; i++) begin
            if (vy > 0) begin
                nx  = vx + (vy >>> i);
                vy  = vy - (vx >>> i);
                acc = acc + arctan_q30(i);
            end else begin
                nx  = vx - (vy >>> i);
                vy  = vy + (vx >>> i);
                acc = acc - arctan_q30(i);
            end
            vx = nx;
        end
        if (acc > HALF_TURN_Q30)
            acc = HALF_TURN_Q30;
        if (acc < -HALF_TURN_Q30)
            acc = -HALF_TURN_Q30;
        mag = (acc < 0) ? -acc : acc;
        mag = (mag + (longint'(1) << (29 - AFB))) >>> (30 - AFB);
        return (acc < 0) ? -int'(mag) : int'(mag);
    endfunction

    function automatic void keep_point(input logic [CB-1:0] x, input logic [CB-1:0] y,
                                       input logic stroke_end);
        kept_point_t k;
        k.x          = x;
        k.y          = y;
        k.stroke_end = stroke_end;
        k.run_last   = 1'b0;
        step_run.push_back(k);
    endfunction

    // point after a kept point: becomes the new segment origin unless it ends the stroke
    function automatic void open_segment(input logic [CB-1:0] x, input logic [CB-1:0] y,
                                         input logic last);
        if (last) begin
            keep_point(x, y, 1'b1);
            trace_phase = SEEK_FIRST;
        end else begin
            seg_org_x   = x;
            seg_org_y   = y;
            trace_phase = SEEK_REFERENCE;
        end
    endfunction

    // distance tests against the origin; the middle band waits for its follower
    function automatic void judge_candidate(input logic [CB-1:0] x, input logic [CB-1:0] y,
                                            input logic last);
        longint dx, dy, d2;
        dx = longint'(x) - longint'(seg_org_x);
        dy = longint'(y) - longint'(seg_org_y);
        d2 = dx * dx + dy * dy;
        pend_valid = 1'b0;
        if (last) begin
            keep_point(x, y, 1'b1);
            trace_phase = SEEK_FIRST;
        end else if (d2 > longint'(far_cfg) * longint'(far_cfg)) begin
            keep_point(x, y, 1'b0);
            trace_phase = SEEK_ORIGIN;
        end else if (d2 < longint'(near_cfg) * longint'(near_cfg)) begin
            trace_phase = SCAN_POINTS;
        end else begin
            pend_x      = x;
            pend_y      = y;
            pend_valid  = 1'b1;
            trace_phase = SCAN_POINTS;
        end
    endfunction

    // Works out the kept points caused by one accepted stroke point.
    function automatic void predict_kept_points(input logic [CB-1:0] x, input logic [CB-1:0] y,
                                                input logic last);
        kept_point_t k;
        int          follow;
        longint      turn;
        bit          turned;
        step_run.delete();
        case (trace_phase)
            SEEK_FIRST: begin
                keep_point(x, y, last);
                trace_phase = last ? SEEK_FIRST : SEEK_ORIGIN;
            end
            SEEK_ORIGIN: open_segment(x, y, last);
            SEEK_REFERENCE: begin
                ref_heading = heading_of(longint'(seg_org_y) - longint'(y),
                                         longint'(seg_org_x) - longint'(x));
                judge_candidate(x, y, last);
            end
            default: begin
                turned = 1'b0;
                if (pend_valid) begin
                    follow = heading_of(longint'(pend_y) - longint'(y),
                                        longint'(pend_x) - longint'(x));
                    // difference is not wrapped around +-pi
                    turn = longint'(ref_heading) - longint'(follow);
                    if (turn < 0)
                        turn = -turn;
                    pend_valid = 1'b0;
                    if (turn > longint'(thr_cfg)) begin
                        keep_point(pend_x, pend_y, 1'b0);
                        open_segment(x, y, last);
                        turned = 1'b1;
                    end
                end
                if (!turned)
                    judge_candidate(x, y, last);
            end
        endcase
        if (step_run.size() > 0) begin
            k = step_run.pop_back();
            k.run_last = 1'b1;
            step_run.push_back(k);
        end
        foreach (step_run[i])
            kept_expected.push_back(step_run[i]);
    endfunction

    // ------------------------------------------------------------------
    // Result checking, sampled at the rising edge
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : check_kept
        kept_point_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (kept_expected.size() == 0) begin
                $error("kept point (%0d,%0d) with no result expected",
                       m_axis_tdata[CB-1:0], m_axis_tdata[2*CB-1:CB]);
                mismatches++;
            end else begin
                want = kept_expected.pop_front();
                check_field("kept_x", want.x, m_axis_tdata[CB-1:0]);
                check_field("kept_y", want.y, m_axis_tdata[2*CB-1:CB]);
                check_field("stroke_end", want.stroke_end, m_axis_tuser);
                check_field("run_last", want.run_last, m_axis_tlast);
            end
        end
    end

    // Receiver: alternating ready / stall stretches of random length; always ready when stalls are off.
    always @(negedge i_clk) begin
        if (!rx_stalls) begin
            m_axis_tready = 1'b1;
        end else if (rx_run_left != 0) begin
            rx_run_left--;
        end else begin
            m_axis_tready = !m_axis_tready;
            rx_run_left   = m_axis_tready ? $urandom_range(0, 6) : $urandom_range(0, 11);
        end
    end

    // Watchdog: no handshake on any port for too long means the block hung.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("polyline_point_decimator verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one stroke point, waits for the handshake, predicts its results,
    // then applies the sender's burst/gap pacing.
    task automatic send_point(input logic [CB-1:0] x, input logic [CB-1:0] y,
                              input logic last);
        @(negedge i_clk);
        s_axis_tdata  = ppd_pkg::TDATA_W'({y, x});
        s_axis_tlast  = last;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_kept_points(x, y, last);
        if (sender_gaps) begin
            if (burst_left == 0) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Stops offering items, waits until every owed result is out, then lets
    // a skipped item still in flight finish before registers are touched.
    task automatic settle_block();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (kept_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input ppd_pkg::t_cfg_idx idx,
                                  input logic [ppd_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = value;
        case (idx)
            ppd_pkg::CFG_NEAR: near_cfg = value[CB-1:0];
            ppd_pkg::CFG_FAR:  far_cfg  = value[CB-1:0];
            ppd_pkg::CFG_THR:  thr_cfg  = value[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_thresholds(input int near, input int far, input int thr);
        write_register(ppd_pkg::CFG_NEAR, near);
        write_register(ppd_pkg::CFG_FAR, far);
        write_register(ppd_pkg::CFG_THR, thr);
    endtask

    function automatic int rand_offset(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : (v > MAX_COORD) ? MAX_COORD : v;
    endfunction

    // Random strokes, always complete: mostly smooth walks of one step scale
    // so that near, band and far cases all show up, plus repeats and wild jumps.
    task automatic run_strokes(input int count);
        int left, len, scale, hx, hy, px, py, step, kind;
        left = count;
        while (left > 0) begin
            case ($urandom_range(0, 19))
                0:       len = 1;
                1:       len = 2;
                2:       len = 3;
                default: len = $urandom_range(4, 40);
            endcase
            if (len > left)
                len = left;
            case ($urandom_range(0, 3))
                0:       scale = 3;
                1:       scale = 12;
                2:       scale = 40;
                default: scale = 150;
            endcase
            px = $urandom_range(0, MAX_COORD);
            py = $urandom_range(0, MAX_COORD);
            hx = rand_offset(scale);
            hy = rand_offset(scale);
            for (step = 0; step < len; step++) begin
                send_point(px, py, step == len - 1);
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    // same point again: zero-length direction
                end else if (kind == 1) begin
                    px = $urandom_range(0, MAX_COORD);
                    py = $urandom_range(0, MAX_COORD);
                end else if (kind <= 5) begin
                    px = clamp_coord(px + hx + rand_offset(2));
                    py = clamp_coord(py + hy + rand_offset(2));
                end else if (kind <= 7) begin
                    px = clamp_coord(px + rand_offset(scale / 4 + 1));
                    py = clamp_coord(py + rand_offset(scale / 4 + 1));
                end else begin
                    hx = rand_offset(scale);
                    hy = rand_offset(scale);
                    px = clamp_coord(px + hx);
                    py = clamp_coord(py + hy);
                end
            end
            left -= len;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-built strokes at the reset thresholds (near 10, far 50, ~7 deg).
    task automatic test_directed_strokes();
        sender_gaps = 1'b0;
        rx_stalls   = 1'b1;
        // single-point strokes at both coordinate extremes
        send_point(0, 0, 1'b1);
        send_point(MAX_COORD, MAX_COORD, 1'b1);
        // two points: the origin is also the last point
        send_point(MAX_COORD, 0, 1'b0);
        send_point(0, MAX_COORD, 1'b1);
        // three points: the reference point ends the stroke
        send_point(1, 2, 1'b0);
        send_point(3, 4, 1'b0);
        send_point(5, 6, 1'b1);
        // zero reference vector, near skip, far boundary held, turn kept
        send_point(10, 10, 1'b0);
        send_point(2000, 2000, 1'b0);       // origin
        send_point(2000, 2000, 1'b0);       // reference on the origin: angle 0, skipped
        send_point(2030, 2040, 1'b0);       // distance exactly far: waits
        send_point(2030, 2040, 1'b0);       // follower on top of it: zero vector
        send_point(2020, 2040, 1'b0);       // straight on: not kept
        send_point(2030, 2030, 1'b0);       // sharp turn: pending kept, new origin
        send_point(2031, 2030, 1'b0);       // reference pointing back: angle +pi
        send_point(2030, 2039, 1'b0);       // inside near: skipped
        send_point(2030, 2040, 1'b0);       // distance exactly near: waits
        send_point(1000, 2040, 1'b1);       // turn with last follower: two results
        // reference at about -pi, beyond far, then origin ends the stroke
        send_point(0, MAX_COORD, 1'b0);
        send_point(500, 500, 1'b0);
        send_point(600, 501, 1'b0);
        send_point(700, 700, 1'b1);
        settle_block();
    endtask

    // Threshold extremes, including the unused register index and
    // junk in the upper data bits of the 12-bit registers.
    task automatic test_register_extremes();
        int k;
        for (k = 0; k < 5; k++) begin
            case (k)
                0: set_thresholds(0, 0, 0);
                1: set_thresholds(MAX_COORD, MAX_COORD, 51472);
                2: set_thresholds(0, MAX_COORD, 16'hFFFF);
                3: set_thresholds(MAX_COORD, 0, 1);
                default: begin
                    write_register(ppd_pkg::CFG_NEAR, 16'hA000 | 16'd10);
                    write_register(ppd_pkg::CFG_FAR, 16'h5000 | 16'd50);
                    write_register(ppd_pkg::CFG_THR, 16'd1001);
                end
            endcase
            write_register(ppd_pkg::CFG_NONE, $urandom_range(0, 16'hFFFF));
            sender_gaps = k[0];
            rx_stalls   = k[1] | k[2];
            run_strokes(32);
            settle_block();
        end
    endtask

    // Random thresholds per phase, varying idle and stall behavior.
    task automatic test_random_strokes();
        int k, near, far, thr;
        for (k = 0; k < 7; k++) begin
            near = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_COORD)
                                               : $urandom_range(0, 40);
            far  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_COORD)
                                               : $urandom_range(0, 300);
            thr  = $urandom_range(0, 1) ? $urandom_range(0, 3000) : $urandom_range(0, 51472);
            set_thresholds(near, far, thr);
            // phase 3 runs with neither side idling
            sender_gaps = (k != 3);
            rx_stalls   = (k != 3) && (k != 5);
            run_strokes(75);
            settle_block();
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = ppd_pkg::CFG_NONE;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_strokes();
        test_register_extremes();
        test_random_strokes();

        if (kept_expected.size() != 0)
            $error("%0d kept points never arrived", kept_expected.size());
        if (mismatches == 0 && kept_expected.size() == 0)
            $display("polyline_point_decimator verification clean");
        else
            $display("polyline_point_decimator verification failed");
        $finish;
    end

endmodule
